/* src/hsv_to_rgb_converter_defines.svh */
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HSV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsv_to_rgb_converter: same-cycle check failed");

// next-cycle implication, checked outside reset
`define HSV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsv_to_rgb_converter: next-cycle check failed");

`endif

/* src/hsv_pkg.sv */
`timescale 1ns / 1ps

package hsv_pkg;

  localparam int NUM_STAGES = 6;

  typedef enum logic [2:0] {
    SEC_0 = 3'd0,
    SEC_1 = 3'd1,
    SEC_2 = 3'd2,
    SEC_3 = 3'd3,
    SEC_4 = 3'd4,
    SEC_5 = 3'd5
  } sector_t;

endpackage

/* src/hsv_to_rgb_converter.sv */
// hsv to rgb, one color per transfer
// six register stages from the input transfer to the output registers
// throughput: one color per cycle; a stalled output holds the full stages up to the first empty one
// reset (rst_n low, synchronous) clears the stage valid bits, datapath is not reset
`timescale 1ns / 1ps

`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter
  import hsv_pkg::*;
#(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [CHANNEL_BITS-1:0] in_hue,
  input  logic [CHANNEL_BITS-1:0] in_saturation,
  input  logic [CHANNEL_BITS-1:0] in_brightness,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [CHANNEL_BITS-1:0] out_red,
  output logic [CHANNEL_BITS-1:0] out_green,
  output logic [CHANNEL_BITS-1:0] out_blue
);

  localparam int N = CHANNEL_BITS;
  localparam logic [N-1:0] M = N'((1 << N) - 1);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] en;

  sector_t        sec_nxt;
  logic [N-1:0]   frac_nxt;

  sector_t        sec1_r, sec2_r, sec3_r, sec4_r, sec5_r;
  logic [N-1:0]   frac1_r, s1_r;
  logic [N-1:0]   v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [2*N-1:0] pp1_r;
  logic [N-1:0]   p_nxt;
  logic [N-1:0]   p2_r, p3_r, p4_r, p5_r;
  logic [2*N-1:0] yq, yt;
  logic [N-1:0]   q_nxt, t_nxt;
  logic [N-1:0]   red_nxt, green_nxt, blue_nxt;
  logic [N-1:0]   red_r, green_r, blue_r;
  logic           in_xfer, out_xfer;
  int             fill_cnt;

  // stage enables, each stage moves when empty or when the next one moves
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // stage 1: sector, fraction, v*(M-s)
  hsv_sector #(.N(N)) u_sector (
    .hue    (in_hue),
    .sector (sec_nxt),
    .frac   (frac_nxt)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sec1_r  <= sec_nxt;
      frac1_r <= frac_nxt;
      s1_r    <= in_saturation;
      v1_r    <= in_brightness;
      pp1_r   <= (2*N)'(in_brightness) * (2*N)'(M - in_saturation);
    end
  end

  // p term and side data, stages 2 to 5
  hsv_divm #(.N(N)) u_p_div (
    .x   (pp1_r),
    .quo (p_nxt),
    .rem ()
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p2_r   <= p_nxt;
      sec2_r <= sec1_r;
      v2_r   <= v1_r;
    end
    if (en[2]) begin
      p3_r   <= p2_r;
      sec3_r <= sec2_r;
      v3_r   <= v2_r;
    end
    if (en[3]) begin
      p4_r   <= p3_r;
      sec4_r <= sec3_r;
      v4_r   <= v3_r;
    end
    if (en[4]) begin
      p5_r   <= p4_r;
      sec5_r <= sec4_r;
      v5_r   <= v4_r;
    end
  end

  hsv_term #(.N(N)) u_q_term (
    .clk (clk),
    .en  (en[4:1]),
    .fac (frac1_r),
    .sat (s1_r),
    .val (v1_r),
    .y   (yq)
  );

  hsv_term #(.N(N)) u_t_term (
    .clk (clk),
    .en  (en[4:1]),
    .fac (M - frac1_r),
    .sat (s1_r),
    .val (v1_r),
    .y   (yt)
  );

  // stage 6: last divide and channel select
  hsv_divm #(.N(N)) u_q_div (
    .x   (yq),
    .quo (q_nxt),
    .rem ()
  );

  hsv_divm #(.N(N)) u_t_div (
    .x   (yt),
    .quo (t_nxt),
    .rem ()
  );

  always_comb begin
    unique case (sec5_r)
      SEC_0: begin
        red_nxt = v5_r;  green_nxt = t_nxt; blue_nxt = p5_r;
      end
      SEC_1: begin
        red_nxt = q_nxt; green_nxt = v5_r;  blue_nxt = p5_r;
      end
      SEC_2: begin
        red_nxt = p5_r;  green_nxt = v5_r;  blue_nxt = t_nxt;
      end
      SEC_3: begin
        red_nxt = p5_r;  green_nxt = q_nxt; blue_nxt = v5_r;
      end
      SEC_4: begin
        red_nxt = t_nxt; green_nxt = p5_r;  blue_nxt = v5_r;
      end
      default: begin
        red_nxt = v5_r;  green_nxt = p5_r;  blue_nxt = q_nxt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid = vld_r[NUM_STAGES-1];
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign fill_cnt = $countones(vld_r);

  `HSV_ASSERT_IMP(a_empty_ready, vld_r == '0, in_ready)
  `HSV_ASSERT_IMP(a_frac_range, vld_r[0], frac1_r != M)
  `HSV_ASSERT_NXT(a_fill_count, in_xfer && !out_xfer, fill_cnt == $past(fill_cnt) + 1)

endmodule

/* src/hsv_divm.sv */
`timescale 1ns / 1ps

// divide by 2^N-1 for dividends up to (2^N-1)^2
module hsv_divm #(
  parameter int N = 8
) (
  input  logic [2*N-1:0] x,
  output logic [N-1:0]   quo,
  output logic [N-1:0]   rem
);

  localparam logic [N:0] M = (N+1)'((1 << N) - 1);

  logic [N-1:0] est;
  logic [N:0]   rsum;
  logic         ge;

  assign est  = x[2*N-1:N];
  assign rsum = {1'b0, x[N-1:0]} + {1'b0, est};
  assign ge   = (rsum >= M);
  assign quo  = ge ? (est + N'(1)) : est;
  assign rem  = ge ? N'(rsum - M) : rsum[N-1:0];

endmodule

/* src/hsv_sector.sv */
`timescale 1ns / 1ps

module hsv_sector
  import hsv_pkg::*;
#(
  parameter int N = 8
) (
  input  logic [N-1:0] hue,
  output sector_t      sector,
  output logic [N-1:0] frac
);

  localparam logic [N+2:0] M1 = (N+3)'((1 << N) - 1);
  localparam logic [N+2:0] M2 = (N+3)'(2 * ((1 << N) - 1));
  localparam logic [N+2:0] M3 = (N+3)'(3 * ((1 << N) - 1));
  localparam logic [N+2:0] M4 = (N+3)'(4 * ((1 << N) - 1));
  localparam logic [N+2:0] M5 = (N+3)'(5 * ((1 << N) - 1));
  localparam logic [N+2:0] M6 = (N+3)'(6 * ((1 << N) - 1));

  logic [N+2:0] h6;
  logic [N+2:0] diff;

  assign h6 = ({3'b000, hue} << 1) + ({3'b000, hue} << 2);

  always_comb begin
    priority if (h6 >= M6) begin
      sector = SEC_0;
      diff   = h6 - M6;
    end else if (h6 >= M5) begin
      sector = SEC_5;
      diff   = h6 - M5;
    end else if (h6 >= M4) begin
      sector = SEC_4;
      diff   = h6 - M4;
    end else if (h6 >= M3) begin
      sector = SEC_3;
      diff   = h6 - M3;
    end else if (h6 >= M2) begin
      sector = SEC_2;
      diff   = h6 - M2;
    end else if (h6 >= M1) begin
      sector = SEC_1;
      diff   = h6 - M1;
    end else begin
      sector = SEC_0;
      diff   = h6;
    end
  end

  assign frac = diff[N-1:0];

endmodule

/* src/hsv_term.sv */
`timescale 1ns / 1ps

// v*(M*M - fac*s)/(M*M), stages 2 to 5, last divide by M left to the caller
module hsv_term #(
  parameter int N = 8
) (
  input  logic           clk,
  input  logic [3:0]     en,
  input  logic [N-1:0]   fac,
  input  logic [N-1:0]   sat,
  input  logic [N-1:0]   val,
  output logic [2*N-1:0] y
);

  localparam logic [2*N-1:0] M_W = (2*N)'((1 << N) - 1);
  localparam logic [2*N-1:0] MM  = M_W * M_W;

  logic [2*N-1:0] fs_r;
  logic [N-1:0]   v2_r;
  logic [N-1:0]   nq3_r, nr3_r, v3_r;
  logic [N-1:0]   nq_nxt, nr_nxt;
  logic [2*N-1:0] a4_r, b4_r;
  logic [N-1:0]   bq_nxt;
  logic [2*N-1:0] y5_r;

  // numerator split into quotient and remainder by M
  hsv_divm #(.N(N)) u_num_div (
    .x   (MM - fs_r),
    .quo (nq_nxt),
    .rem (nr_nxt)
  );

  hsv_divm #(.N(N)) u_low_div (
    .x   (b4_r),
    .quo (bq_nxt),
    .rem ()
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fs_r <= (2*N)'(fac) * (2*N)'(sat);
      v2_r <= val;
    end
    if (en[1]) begin
      nq3_r <= nq_nxt;
      nr3_r <= nr_nxt;
      v3_r  <= v2_r;
    end
    if (en[2]) begin
      a4_r <= (2*N)'(v3_r) * (2*N)'(nq3_r);
      b4_r <= (2*N)'(v3_r) * (2*N)'(nr3_r);
    end
    if (en[3]) begin
      y5_r <= a4_r + (2*N)'(bq_nxt);
    end
  end

  assign y = y5_r;

endmodule

/* sim/hsv_to_rgb_converter_tb.sv */
`timescale 1ns / 1ps

module hsv_to_rgb_converter_tb;
  import hsv_pkg::*;

  localparam int CB = 8;
  localparam int RANDOM_ITEMS = 1750;
  localparam int PHASE_ITEMS = 250;

  typedef struct packed {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [CB-1:0] hue;
    logic [CB-1:0] sat;
    logic [CB-1:0] bri;
    logic          fixed_en;
    rgb_t          fixed;
  } dir_row_t;

  localparam int DIR_ROWS = 21;

  // rows with fixed_en set carry their expected color, the rest use the predictor
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{8'd0,   8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
    '{8'd0,   8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{8'd123, 8'd0,   8'd77,  1'b1, '{8'd77,  8'd77,  8'd77}},
    '{8'd0,   8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
    '{8'd255, 8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{8'd42,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd43,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd85,  8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd128, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd170, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd212, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd213, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd254, 8'd255, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd1,   8'd1,   8'd1,   1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd128, 8'd128, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd85,  8'd170, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd170, 8'd85,  8'd60,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd255, 8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{8'd0,   8'd128, 8'd200, 1'b0, '{8'd0,   8'd0,   8'd0}}
  };

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [CB-1:0] in_hue;
  logic [CB-1:0] in_saturation;
  logic [CB-1:0] in_brightness;
  logic          out_valid;
  logic          out_ready;
  logic [CB-1:0] out_red;
  logic [CB-1:0] out_green;
  logic [CB-1:0] out_blue;

  rgb_t rgb_expect_q [$];
  rgb_t want_rgb;
  logic row_fixed_en;
  rgb_t row_fixed;
  logic no_idle;
  int   errors;

  always #6 clk = ~clk;

  hsv_to_rgb_converter #(
    .CHANNEL_BITS(CB)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_hue       (in_hue),
    .in_saturation(in_saturation),
    .in_brightness(in_brightness),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue)
  );

  function automatic rgb_t hsv_to_rgb(input logic [CB-1:0] h, s, v);
    int unsigned m;
    int unsigned mm;
    int unsigned h6;
    int unsigned frac;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_t     sec;
    rgb_t        c;
    m    = (1 << CB) - 1;
    mm   = m * m;
    h6   = int'(h) * 6;
    sec  = sector_t'((h6 / m) % 6);
    frac = h6 % m;
    p    = (int'(v) * (m - int'(s))) / m;
    q    = (int'(v) * (mm - frac * int'(s))) / mm;
    t    = (int'(v) * (mm - (m - frac) * int'(s))) / mm;
    case (sec)
      SEC_0: c = '{v, t[CB-1:0], p[CB-1:0]};
      SEC_1: c = '{q[CB-1:0], v, p[CB-1:0]};
      SEC_2: c = '{p[CB-1:0], v, t[CB-1:0]};
      SEC_3: c = '{p[CB-1:0], q[CB-1:0], v};
      SEC_4: c = '{t[CB-1:0], p[CB-1:0], v};
      default: c = '{v, p[CB-1:0], q[CB-1:0]};
    endcase
    return c;
  endfunction

  function automatic logic [CB-1:0] rand_channel();
    if ($urandom_range(0, 6) == 0) begin
      return ($urandom_range(0, 1) == 1) ? {CB{1'b1}} : '0;
    end
    return CB'($urandom_range(0, (1 << CB) - 1));
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic check_channel(input string name, input logic [CB-1:0] want, got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_color(input logic [CB-1:0] h, s, v, input logic fixed_en,
                            input rgb_t fixed);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_hue        <= h;
    in_saturation <= s;
    in_brightness <= v;
    row_fixed_en  <= fixed_en;
    row_fixed     <= fixed;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (rgb_expect_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected color, expected none, got %0d %0d %0d",
                   $realtime, out_red, out_green, out_blue);
        end else begin
          want_rgb = rgb_expect_q.pop_front();
          check_channel("red", want_rgb.red, out_red);
          check_channel("green", want_rgb.green, out_green);
          check_channel("blue", want_rgb.blue, out_blue);
        end
      end
      if (in_valid && in_ready) begin
        rgb_expect_q.push_back(row_fixed_en ? row_fixed
                               : hsv_to_rgb(in_hue, in_saturation, in_brightness));
      end
    end
  end

  // output side
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // input side
  initial begin
    errors        = 0;
    no_idle       = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_hue        = '0;
    in_saturation = '0;
    in_brightness = '0;
    row_fixed_en  = 1'b0;
    row_fixed     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_color(dir_rows[i].hue, dir_rows[i].sat, dir_rows[i].bri,
                 dir_rows[i].fixed_en, dir_rows[i].fixed);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // alternate phases with idling and back-to-back stretches
      no_idle = ((n / PHASE_ITEMS) % 2) == 1;
      if (n == RANDOM_ITEMS / 2) begin
        in_valid <= 1'b0;
        while (rgb_expect_q.size() != 0) @(negedge clk);
      end
      send_color(rand_channel(), rand_channel(), rand_channel(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (rgb_expect_q.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/hsv_pkg.sv
src/hsv_divm.sv
src/hsv_sector.sv
src/hsv_term.sv
src/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_tb.sv
